/* src/lab_pkg.sv */
// Shared types and constants for the look-at basis pipeline.
// No dependencies; imported by lab_norm, lab_cross and the top level.
`default_nettype none

package lab_pkg;

  localparam int IN_W      = 32;
  localparam int OUT_FRAC  = 14;
  localparam int OUT_W     = OUT_FRAC + 2;
  localparam int UNIT_FRAC = 30;
  localparam int THR_W     = 16;
  localparam int ADDR_W    = 3;
  localparam int VEC_W     = 64;
  localparam int MAG_W     = 30;
  localparam int SQ_W      = 2 * MAG_W + 2;
  localparam int TRIAL_W   = SQ_W + 1;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int QUO_W     = UNIT_FRAC + 1;
  localparam int DIV_W     = MAG_W + UNIT_FRAC + 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int NRM_LAT   = 7 + SQ_STEPS + DIV_STEPS;
  localparam int TOP_LAT   = 2 * NRM_LAT + 5;

  localparam logic REG_THR = 1'b0;

  typedef enum logic {
    FRAC_UNIT = 1'b0,
    FRAC_OUT  = 1'b1
  } frac_sel_e;

  typedef logic signed [VEC_W-1:0] comp_t;
  typedef logic signed [QUO_W:0]   unit_t;
  typedef logic signed [OUT_W-1:0] out_t;

  typedef struct packed {
    logic      valid;
    frac_sel_e fsel;
  } nrm_ctl_t;

  typedef struct packed {
    logic valid;
    logic vert;
    logic deg;
  } crs_ctl_t;

endpackage

`default_nettype wire

/* src/lab_norm.sv */
// Pipelined vector normaliser: block shift, sum of squares, root, three dividers.
// Depends on lab_pkg.
`default_nettype none

module lab_norm
  import lab_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  nrm_ctl_t ctl_i,
  input  comp_t    vec_i [3],
  output logic     valid_o,
  output unit_t    unit_o [3]
);

  logic [NRM_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NRM_LAT-2:0], ctl_i.valid};
    end
  end

  assign valid_o = vld_q[NRM_LAT-1];

  // magnitude and sign
  logic [VEC_W-1:0] s1_mag_q [3];
  logic [2:0]       s1_neg_q;
  frac_sel_e        s1_fsel_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s1_neg_q[i] <= vec_i[i][VEC_W-1];
      s1_mag_q[i] <= vec_i[i][VEC_W-1] ? VEC_W'(-vec_i[i]) : VEC_W'(vec_i[i]);
    end
    s1_fsel_q <= ctl_i.fsel;
  end

  // block shift, coarse steps
  logic [VEC_W-1:0] s1_or;
  logic [VEC_W-1:0] s2_or_d;
  logic [VEC_W-1:0] s2_mag_d [3];

  assign s1_or = s1_mag_q[0] | s1_mag_q[1] | s1_mag_q[2];

  always_comb begin
    s2_or_d = s1_or;
    for (int i = 0; i < 3; i++) s2_mag_d[i] = s1_mag_q[i];
    for (int s = 0; s < 3; s++) begin
      if ((s2_or_d >> (VEC_W - (32 >> s))) == '0) begin
        s2_or_d = s2_or_d << (32 >> s);
        for (int i = 0; i < 3; i++) s2_mag_d[i] = s2_mag_d[i] << (32 >> s);
      end
    end
  end

  logic [VEC_W-1:0] s2_or_q;
  logic [VEC_W-1:0] s2_mag_q [3];
  logic [2:0]       s2_neg_q;
  logic             s2_zero_q;
  frac_sel_e        s2_fsel_q;

  always_ff @(posedge clk_i) begin
    s2_or_q   <= s2_or_d;
    s2_mag_q  <= s2_mag_d;
    s2_neg_q  <= s1_neg_q;
    s2_zero_q <= (s1_or == '0);
    s2_fsel_q <= s1_fsel_q;
  end

  // block shift, fine steps; leading one lands on bit MAG_W-1
  logic [VEC_W-1:0] s3_or_d;
  logic [VEC_W-1:0] s3_mag_d [3];

  always_comb begin
    s3_or_d = s2_or_q;
    for (int i = 0; i < 3; i++) s3_mag_d[i] = s2_mag_q[i];
    for (int s = 3; s < 6; s++) begin
      if ((s3_or_d >> (VEC_W - (32 >> s))) == '0) begin
        s3_or_d = s3_or_d << (32 >> s);
        for (int i = 0; i < 3; i++) s3_mag_d[i] = s3_mag_d[i] << (32 >> s);
      end
    end
  end

  logic [MAG_W-1:0] s3_mag_q [3];
  logic [2:0]       s3_neg_q;
  logic             s3_zero_q;
  frac_sel_e        s3_fsel_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) s3_mag_q[i] <= s3_mag_d[i][VEC_W-1 -: MAG_W];
    s3_neg_q  <= s2_neg_q;
    s3_zero_q <= s2_zero_q;
    s3_fsel_q <= s2_fsel_q;
  end

  // squares
  logic [2*MAG_W-1:0] s4_sq_q  [3];
  logic [MAG_W-1:0]   s4_mag_q [3];
  logic [2:0]         s4_neg_q;
  logic               s4_zero_q;
  frac_sel_e          s4_fsel_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) s4_sq_q[i] <= s3_mag_q[i] * s3_mag_q[i];
    s4_mag_q  <= s3_mag_q;
    s4_neg_q  <= s3_neg_q;
    s4_zero_q <= s3_zero_q;
    s4_fsel_q <= s3_fsel_q;
  end

  // integer square root, one root bit a stage
  logic [SQ_W-1:0]   sq_rem_q  [SQ_STEPS+1];
  logic [ROOT_W-1:0] sq_root_q [SQ_STEPS+1];
  logic [MAG_W-1:0]  sq_mag_q  [SQ_STEPS+1][3];
  logic [2:0]        sq_neg_q  [SQ_STEPS+1];
  logic [SQ_STEPS:0] sq_zero_q;
  frac_sel_e         sq_fsel_q [SQ_STEPS+1];

  always_ff @(posedge clk_i) begin
    sq_rem_q[0]  <= SQ_W'(s4_sq_q[0]) + SQ_W'(s4_sq_q[1]) + SQ_W'(s4_sq_q[2]);
    sq_root_q[0] <= '0;
    sq_mag_q[0]  <= s4_mag_q;
    sq_neg_q[0]  <= s4_neg_q;
    sq_zero_q[0] <= s4_zero_q;
    sq_fsel_q[0] <= s4_fsel_q;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam int Pos = ROOT_W - 1 - k;
    logic [TRIAL_W-1:0] trial;
    logic [TRIAL_W-1:0] rem_ext;

    assign trial   = (TRIAL_W'(sq_root_q[k]) << (Pos + 1)) | (TRIAL_W'(1) << (2 * Pos));
    assign rem_ext = TRIAL_W'(sq_rem_q[k]);

    always_ff @(posedge clk_i) begin
      if (rem_ext >= trial) begin
        sq_rem_q[k+1]  <= SQ_W'(rem_ext - trial);
        sq_root_q[k+1] <= sq_root_q[k] | (ROOT_W'(1) << Pos);
      end else begin
        sq_rem_q[k+1]  <= sq_rem_q[k];
        sq_root_q[k+1] <= sq_root_q[k];
      end
      sq_mag_q[k+1]  <= sq_mag_q[k];
      sq_neg_q[k+1]  <= sq_neg_q[k];
      sq_zero_q[k+1] <= sq_zero_q[k];
      sq_fsel_q[k+1] <= sq_fsel_q[k];
    end
  end

  // rounded quotients, one quotient bit a stage
  logic [DIV_W-1:0]   dv_rem_q  [DIV_STEPS+1][3];
  logic [QUO_W-1:0]   dv_quo_q  [DIV_STEPS+1][3];
  logic [ROOT_W-1:0]  dv_n_q    [DIV_STEPS+1];
  logic [2:0]         dv_neg_q  [DIV_STEPS+1];
  logic [DIV_STEPS:0] dv_zero_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (sq_fsel_q[SQ_STEPS] == FRAC_OUT) begin
        dv_rem_q[0][i] <= (DIV_W'(sq_mag_q[SQ_STEPS][i]) << OUT_FRAC)
                          + DIV_W'(sq_root_q[SQ_STEPS] >> 1);
      end else begin
        dv_rem_q[0][i] <= (DIV_W'(sq_mag_q[SQ_STEPS][i]) << UNIT_FRAC)
                          + DIV_W'(sq_root_q[SQ_STEPS] >> 1);
      end
      dv_quo_q[0][i] <= '0;
    end
    dv_n_q[0]    <= sq_root_q[SQ_STEPS];
    dv_neg_q[0]  <= sq_neg_q[SQ_STEPS];
    dv_zero_q[0] <= sq_zero_q[SQ_STEPS];
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int Pos = QUO_W - 1 - k;
    logic [DIV_W-1:0] sub;

    assign sub = DIV_W'(dv_n_q[k]) << Pos;

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_q[k][i] >= sub) begin
          dv_rem_q[k+1][i] <= dv_rem_q[k][i] - sub;
          dv_quo_q[k+1][i] <= dv_quo_q[k][i] | (QUO_W'(1) << Pos);
        end else begin
          dv_rem_q[k+1][i] <= dv_rem_q[k][i];
          dv_quo_q[k+1][i] <= dv_quo_q[k][i];
        end
      end
      dv_n_q[k+1]    <= dv_n_q[k];
      dv_neg_q[k+1]  <= dv_neg_q[k];
      dv_zero_q[k+1] <= dv_zero_q[k];
    end
  end

  // sign back on
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_q[DIV_STEPS]) begin
        unit_o[i] <= '0;
      end else if (dv_neg_q[DIV_STEPS][i]) begin
        unit_o[i] <= -unit_t'({1'b0, dv_quo_q[DIV_STEPS][i]});
      end else begin
        unit_o[i] <= unit_t'({1'b0, dv_quo_q[DIV_STEPS][i]});
      end
    end
  end

endmodule

`default_nettype wire

/* src/lab_cross.sv */
// Two-stage cross product unit forming raw up and right from forward and projection.
// Depends on lab_pkg.
`default_nettype none

module lab_cross
  import lab_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  crs_ctl_t ctl_i,
  input  unit_t    f_i  [3],
  input  unit_t    pu_i [3],
  input  out_t     fo_i [3],
  output crs_ctl_t ctl_o,
  output comp_t    up_o [3],
  output comp_t    rt_o [3],
  output out_t     fo_o [3]
);

  crs_ctl_t x1_ctl_q;
  comp_t    x1_a_q, x1_b_q, x1_c_q, x1_d_q;
  unit_t    x1_pu_q [3];
  out_t     x1_fo_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_ctl_q <= '0;
      ctl_o    <= '0;
    end else begin
      x1_ctl_q <= ctl_i;
      ctl_o    <= x1_ctl_q;
    end
  end

  // products, operands chosen by plane
  always_ff @(posedge clk_i) begin
    x1_a_q  <= f_i[1] * (ctl_i.vert ? pu_i[1] : pu_i[0]);
    x1_b_q  <= f_i[2] * pu_i[2];
    x1_c_q  <= f_i[0] * (ctl_i.vert ? pu_i[1] : pu_i[0]);
    x1_d_q  <= (ctl_i.vert ? f_i[0] : f_i[1]) * pu_i[2];
    x1_pu_q <= pu_i;
    x1_fo_q <= fo_i;
  end

  always_ff @(posedge clk_i) begin
    if (x1_ctl_q.vert) begin
      up_o[0] <= '0;
      up_o[1] <= VEC_W'(x1_pu_q[2]);
      up_o[2] <= -VEC_W'(x1_pu_q[1]);
      rt_o[0] <= -(x1_a_q + x1_b_q);
      rt_o[1] <= x1_c_q;
      rt_o[2] <= x1_d_q;
    end else begin
      up_o[0] <= -x1_a_q;
      up_o[1] <= x1_c_q + x1_b_q;
      up_o[2] <= -x1_d_q;
      rt_o[0] <= VEC_W'(x1_pu_q[2]);
      rt_o[1] <= '0;
      rt_o[2] <= -VEC_W'(x1_pu_q[0]);
    end
    fo_o <= x1_fo_q;
  end

endmodule

`default_nettype wire

/* src/look_at_basis_from_direction.sv */
// Top level of the look-at basis engine: register port, input stages, output stage.
// Depends on lab_pkg, lab_norm and lab_cross.
//
// A direction beat (dir_x_i, dir_y_i, dir_z_i, signed Q16.16) is taken on any
// clock edge with start high; busy stays low, so a new beat may follow in
// every cycle. Each beat yields one result beat: forward, up and right in
// signed Q1.14 plus degenerate_o, shown for a single cycle with done_o high.
// A result beat passes two normalisers in series (69 stages each: root and divide
// retire one bit a stage) plus input, cross product and output stages.
// Throughput is one beat per cycle.
// The result cannot be held off; the receiver must take it in its cycle.
// vertical_threshold sits at byte address 0 on the APB port and resets to 1; the
// user must write it only while no beat is in flight, as the block does not
// enforce this. Reset empties the pipeline and drops any beats in it.
`default_nettype none

module look_at_basis_from_direction
  import lab_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  dir_x_i,
  input  logic signed [IN_W-1:0]  dir_y_i,
  input  logic signed [IN_W-1:0]  dir_z_i,
  output logic                    done_o,
  output out_t                    fwd_x_o,
  output out_t                    fwd_y_o,
  output out_t                    fwd_z_o,
  output out_t                    up_x_o,
  output out_t                    up_y_o,
  output out_t                    up_z_o,
  output out_t                    right_x_o,
  output out_t                    right_y_o,
  output out_t                    right_z_o,
  output logic                    degenerate_o
);

  // register port
  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (psel && penable && pwrite && paddr[2] == REG_THR) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THR) ? 32'(thr_q) : '0;
  assign busy   = 1'b0;

  // input stages
  logic                   t0_vld_q, t1_vld_q;
  logic signed [IN_W-1:0] t0_d_q [3];
  comp_t                  t1_d_q [3];
  comp_t                  t1_p_q [3];
  logic                   t1_vert_q, t1_deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_vld_q <= 1'b0;
      t1_vld_q <= 1'b0;
    end else begin
      t0_vld_q <= start && !busy;
      t1_vld_q <= t0_vld_q;
    end
  end

  logic [IN_W-1:0] ax, az;
  logic            vert;
  comp_t           p_d [3];

  assign ax   = t0_d_q[0][IN_W-1] ? IN_W'(-t0_d_q[0]) : IN_W'(t0_d_q[0]);
  assign az   = t0_d_q[2][IN_W-1] ? IN_W'(-t0_d_q[2]) : IN_W'(t0_d_q[2]);
  assign vert = (ax < IN_W'(thr_q)) && (az < IN_W'(thr_q));

  always_comb begin
    p_d[0] = vert ? '0 : VEC_W'(t0_d_q[0]);
    p_d[1] = vert ? VEC_W'(t0_d_q[1]) : '0;
    p_d[2] = VEC_W'(t0_d_q[2]);
  end

  always_ff @(posedge clk_i) begin
    t0_d_q[0] <= dir_x_i;
    t0_d_q[1] <= dir_y_i;
    t0_d_q[2] <= dir_z_i;
    for (int i = 0; i < 3; i++) t1_d_q[i] <= VEC_W'(t0_d_q[i]);
    t1_p_q    <= p_d;
    t1_vert_q <= vert;
    t1_deg_q  <= (p_d[0] == '0) && (p_d[1] == '0) && (p_d[2] == '0);
  end

  // forward and projection units, plane flags ride alongside
  nrm_ctl_t unit_ctl, out_ctl;
  logic     n1_vld;
  unit_t    n1_unit [3];
  unit_t    n2_unit [3];
  unit_t    n3_unit [3];

  assign unit_ctl = '{valid: t1_vld_q, fsel: FRAC_UNIT};
  assign out_ctl  = '{valid: t1_vld_q, fsel: FRAC_OUT};

  lab_norm u_nrm_fwd (
    .clk_i, .rst_ni, .ctl_i(unit_ctl), .vec_i(t1_d_q), .valid_o(n1_vld), .unit_o(n1_unit)
  );

  lab_norm u_nrm_prj (
    .clk_i, .rst_ni, .ctl_i(unit_ctl), .vec_i(t1_p_q), .valid_o(), .unit_o(n2_unit)
  );

  lab_norm u_nrm_fwo (
    .clk_i, .rst_ni, .ctl_i(out_ctl), .vec_i(t1_d_q), .valid_o(), .unit_o(n3_unit)
  );

  logic [NRM_LAT-1:0] vl_vert_q, vl_deg_q;

  always_ff @(posedge clk_i) begin
    vl_vert_q <= {vl_vert_q[NRM_LAT-2:0], t1_vert_q};
    vl_deg_q  <= {vl_deg_q[NRM_LAT-2:0], t1_deg_q};
  end

  crs_ctl_t crs_in, crs_out;
  out_t     fo_in [3];
  out_t     fo_x2 [3];
  comp_t    up_raw [3];
  comp_t    rt_raw [3];

  assign crs_in = '{valid: n1_vld, vert: vl_vert_q[NRM_LAT-1], deg: vl_deg_q[NRM_LAT-1]};

  always_comb begin
    for (int i = 0; i < 3; i++) fo_in[i] = out_t'(n3_unit[i][OUT_W-1:0]);
  end

  lab_cross u_cross (
    .clk_i, .rst_ni,
    .ctl_i(crs_in), .f_i(n1_unit), .pu_i(n2_unit), .fo_i(fo_in),
    .ctl_o(crs_out), .up_o(up_raw), .rt_o(rt_raw), .fo_o(fo_x2)
  );

  // output units
  nrm_ctl_t fin_ctl;
  logic     n4_vld;
  unit_t    n4_unit [3];
  unit_t    n5_unit [3];

  assign fin_ctl = '{valid: crs_out.valid, fsel: FRAC_OUT};

  lab_norm u_nrm_up (
    .clk_i, .rst_ni, .ctl_i(fin_ctl), .vec_i(up_raw), .valid_o(n4_vld), .unit_o(n4_unit)
  );

  lab_norm u_nrm_rt (
    .clk_i, .rst_ni, .ctl_i(fin_ctl), .vec_i(rt_raw), .valid_o(), .unit_o(n5_unit)
  );

  out_t               fl_fo_q [NRM_LAT][3];
  logic [NRM_LAT-1:0] fl_deg_q;

  always_ff @(posedge clk_i) begin
    fl_fo_q[0] <= fo_x2;
    for (int k = 1; k < NRM_LAT; k++) fl_fo_q[k] <= fl_fo_q[k-1];
    fl_deg_q <= {fl_deg_q[NRM_LAT-2:0], crs_out.deg};
  end

  // result beat
  logic deg_out;

  assign deg_out = fl_deg_q[NRM_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= n4_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    degenerate_o <= deg_out;
    fwd_x_o      <= deg_out ? '0 : fl_fo_q[NRM_LAT-1][0];
    fwd_y_o      <= deg_out ? '0 : fl_fo_q[NRM_LAT-1][1];
    fwd_z_o      <= deg_out ? '0 : fl_fo_q[NRM_LAT-1][2];
    up_x_o       <= deg_out ? '0 : out_t'(n4_unit[0][OUT_W-1:0]);
    up_y_o       <= deg_out ? '0 : out_t'(n4_unit[1][OUT_W-1:0]);
    up_z_o       <= deg_out ? '0 : out_t'(n4_unit[2][OUT_W-1:0]);
    right_x_o    <= deg_out ? '0 : out_t'(n5_unit[0][OUT_W-1:0]);
    right_y_o    <= deg_out ? '0 : out_t'(n5_unit[1][OUT_W-1:0]);
    right_z_o    <= deg_out ? '0 : out_t'(n5_unit[2][OUT_W-1:0]);
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##TOP_LAT done_o)
    else $error("result beat missing at expected latency");

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> fwd_x_o == '0 && fwd_y_o == '0 && fwd_z_o == '0 &&
      up_x_o == '0 && up_y_o == '0 && up_z_o == '0 &&
      right_x_o == '0 && right_y_o == '0 && right_z_o == '0)
    else $error("degenerate beat with non-zero vectors");

  a_fwd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !degenerate_o |->
      fwd_x_o <= 16'sd16384 && fwd_x_o >= -16'sd16384 &&
      fwd_y_o <= 16'sd16384 && fwd_y_o >= -16'sd16384 &&
      fwd_z_o <= 16'sd16384 && fwd_z_o >= -16'sd16384)
    else $error("forward component outside unit range");
`endif

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for look_at_basis_from_direction: directed and random directions
// over several threshold settings, predicted by an in-bench fixed-point basis model.
// Depends on lab_pkg and the look_at_basis_from_direction RTL.
`timescale 1ns / 100ps

module tb;
  import lab_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [ADDR_W-1:0] ADDR_THR  = ADDR_W'(REG_THR) << 2;
  localparam logic [ADDR_W-1:0] ADDR_VOID = ADDR_W'(4);

  typedef struct packed {
    logic signed [IN_W-1:0] x, y, z;
  } dir_t;

  typedef struct packed {
    out_t fx, fy, fz, ux, uy, uz, rx, ry, rz;
    logic deg;
  } basis_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready, start = 1'b0, busy, done_o, degenerate_o;
  logic signed [IN_W-1:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  out_t fwd_x_o, fwd_y_o, fwd_z_o, up_x_o, up_y_o, up_z_o, right_x_o, right_y_o, right_z_o;

  look_at_basis_from_direction dut (.*);

  initial forever #4 clk_i = ~clk_i;

  dir_t   dir_pending[$];
  basis_t basis_due[$];
  longint thr_model = 1;
  bit     bursts_on = 1'b1;
  int     errors = 0;
  int     quiet_cycles = 0;
  int     hold = 0;

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void unit_vec(input longint v[3], input int frac, output longint r[3]);
    longint unsigned mag[3], m, ss, n, q;
    m = 0;
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      r = '{0, 0, 0};
      return;
    end
    while (m >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
      m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
      m <<= 1;
    end
    for (int i = 0; i < 3; i++) ss += mag[i] * mag[i];
    n = root64(ss);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << frac) + (n >> 1)) / n;
      r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic basis_t camera_basis(dir_t d);
    longint dv[3], p[3], f[3], pu[3], upr[3], rtr[3], fo[3], uo[3], ro[3];
    longint ax, az;
    bit vert;
    basis_t b;
    dv = '{longint'(d.x), longint'(d.y), longint'(d.z)};
    ax = dv[0] < 0 ? -dv[0] : dv[0];
    az = dv[2] < 0 ? -dv[2] : dv[2];
    vert = ax < thr_model && az < thr_model;
    p = '{vert ? 0 : dv[0], vert ? dv[1] : 0, dv[2]};
    b = '0;
    if (p[0] == 0 && p[1] == 0 && p[2] == 0) begin
      b.deg = 1'b1;
      return b;
    end
    unit_vec(dv, UNIT_FRAC, f);
    unit_vec(p, UNIT_FRAC, pu);
    if (vert) begin
      upr = '{0, pu[2], -pu[1]};
      rtr = '{-(f[1] * pu[1] + f[2] * pu[2]), f[0] * pu[1], f[0] * pu[2]};
    end else begin
      rtr = '{pu[2], 0, -pu[0]};
      upr = '{-(f[1] * pu[0]), f[0] * pu[0] + f[2] * pu[2], -(f[1] * pu[2])};
    end
    unit_vec(dv, OUT_FRAC, fo);
    unit_vec(upr, OUT_FRAC, uo);
    unit_vec(rtr, OUT_FRAC, ro);
    b.fx = out_t'(fo[0]); b.fy = out_t'(fo[1]); b.fz = out_t'(fo[2]);
    b.ux = out_t'(uo[0]); b.uy = out_t'(uo[1]); b.uz = out_t'(uo[2]);
    b.rx = out_t'(ro[0]); b.ry = out_t'(ro[1]); b.rz = out_t'(ro[2]);
    return b;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    dir_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) basis_due.push_back(camera_basis('{dir_x_i, dir_y_i, dir_z_i}));
      if (!(start && busy)) begin
        if (hold > 0) begin
          hold--;
          start <= 1'b0;
        end else if (dir_pending.size() == 0) begin
          start <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 7) == 0) begin
          hold = $urandom_range(0, 10);
          start <= 1'b0;
        end else begin
          nxt = dir_pending.pop_front();
          dir_x_i <= nxt.x;
          dir_y_i <= nxt.y;
          dir_z_i <= nxt.z;
          start   <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    basis_t got, want;
    if (rst_ni && done_o) begin
      got = '{fwd_x_o, fwd_y_o, fwd_z_o, up_x_o, up_y_o, up_z_o,
              right_x_o, right_y_o, right_z_o, degenerate_o};
      if (basis_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = basis_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("basis mismatch: exp %p got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_THR) thr_model = data & 32'hFFFF;
  endtask

  task automatic settle();
    while (dir_pending.size() != 0 || basis_due.size() != 0 || start) @(posedge clk_i);
    repeat (TOP_LAT + 4) @(posedge clk_i);
  endtask

  task automatic add_dir(int x, int y, int z);
    dir_pending.push_back('{x, y, z});
  endtask

  function automatic int pick_comp(int kind);
    int t;
    t = int'(thr_model);
    case (kind)
      0: return $urandom;
      1: return int'($urandom_range(0, 600)) - 300;
      2: return t == 0 ? 0 : int'($urandom_range(0, 2 * t)) - t;
      3: return 0;
      4: case ($urandom_range(0, 4))
           0: return 32'sh8000_0000;
           1: return 32'sh7FFF_FFFF;
           2: return 1;
           3: return -1;
           default: return 0;
         endcase
      default: return int'($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic add_random(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 5);
      if (k == 2) add_dir(pick_comp(2), pick_comp(0), pick_comp(2));
      else add_dir(pick_comp($urandom_range(0, 5)), pick_comp($urandom_range(0, 5)),
                   pick_comp($urandom_range(0, 5)));
      if ($urandom_range(0, 3) == 0) begin
        dir_pending[$].x = pick_comp(k);
        dir_pending[$].z = pick_comp(k);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset threshold of one: axis cases, zero direction, extremes
    add_dir(0, 0, 0);
    add_dir(0, 65536, 0);
    add_dir(0, -65536, 0);
    add_dir(0, 0, 65536);
    add_dir(0, 3, -7);
    add_dir(65536, 0, 0);
    add_dir(-1, 0, 0);
    add_dir(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    add_dir(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_dir(32'sh8000_0000, 32'sh7FFF_FFFF, 1);
    add_dir(1, 1, 1);
    add_dir(-1, -1, -1);
    add_dir(0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    add_random(100);
    while (dir_pending.size() != 0 || basis_due.size() != 0) @(posedge clk_i);
    add_random(100);
    settle();

    // zero threshold: never vertical, x = z = 0 gives an empty projection
    reg_write(ADDR_THR, 32'd0);
    add_dir(0, 65536, 0);
    add_dir(0, -5, 0);
    add_dir(1, 0, 0);
    add_dir(0, 0, 0);
    add_random(200);
    settle();

    // full threshold: small x with y = z = 0 gives an empty projection
    reg_write(ADDR_THR, 32'hFFFF_FFFF);
    add_dir(5, 0, 0);
    add_dir(-65534, 0, 0);
    add_dir(65534, 9, -65534);
    add_dir(65535, 9, 0);
    add_dir(0, 0, 0);
    add_random(200);
    settle();

    reg_write(ADDR_VOID, 32'd3);
    reg_write(ADDR_W'(7), 32'd0);
    add_dir(100, 7, 100);
    add_random(100);
    settle();

    reg_write(ADDR_THR, $urandom_range(2, 65534));
    add_random(150);
    settle();

    reg_write(ADDR_THR, 32'd1);
    bursts_on = 1'b0;
    add_random(150);
    settle();

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
src/lab_pkg.sv
src/lab_norm.sv
src/lab_cross.sv
src/look_at_basis_from_direction.sv
bench/tb.sv
